// ===== rtl/core/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// types, codes and fixed constants of the page table walker
// ----------------------------------------------------------------------------
package ptw_pkg;

    // input item kinds (s_tuser)
    localparam logic OP_START = 1'b0;
    localparam logic OP_ENTRY = 1'b1;

    // result status codes (m_tuser)
    typedef logic [1:0] ptw_status_t;
    localparam ptw_status_t ST_READ_REQ  = 2'd0;
    localparam ptw_status_t ST_LAST      = 2'd1;
    localparam ptw_status_t ST_EARLY     = 2'd2;
    localparam ptw_status_t ST_UNSUP     = 2'd3;

    // register indexes, one register per 8 bytes
    typedef logic [1:0] ptw_reg_idx_t;
    localparam ptw_reg_idx_t REG_CTRL_LOW  = 2'd0;
    localparam ptw_reg_idx_t REG_CTRL_HIGH = 2'd1;
    localparam ptw_reg_idx_t REG_ROOT_LOW  = 2'd2;
    localparam ptw_reg_idx_t REG_ROOT_HIGH = 2'd3;

    // entry bits that carry the next table address
    localparam logic [63:0] ENTRY_ADDR_MASK = 64'h0000_FFFF_FFFF_F000;

    // huge leaf marker bits
    localparam int HUGE_BIT_A = 6;
    localparam int HUGE_BIT_B = 12;

    // largest supported index width
    localparam logic [4:0] MAX_WIDTH = 5'd12;

    // widths
    localparam int LEVEL_W = 3;
    localparam int INDEX_W = 12;
    localparam int RADDR_W = 49;
    localparam int BASE_W  = 48;

    typedef logic [LEVEL_W-1:0] ptw_level_t;

endpackage

// ===== rtl/core/page_table_walker_top.sv =====
// ----------------------------------------------------------------------------
// page_table_walker_top
// multi-level page table walker with a stream channel in and out
// ----------------------------------------------------------------------------
// usage
//   s_* carries walk starts (s_tuser = 0, virtual address) and table entries
//   returned from memory (s_tuser = 1, entry data). m_* carries one result per
//   start and per entry of a running walk: a read request for the next entry,
//   or the end of the walk (last level, stopped early, unsupported config).
//   an entry that arrives with no walk running gives no result.
//   the apb port holds the two walk-control words and the two root pointers;
//   the user must write it only while no item is in flight; the block does
//   not enforce this. an open walk sees a new setting on its next entry
// stages and throughput
//   an item is held in the input register and is worked on against the walk
//   state there; its result is then registered in the output register. one
//   item is accepted every cycle while the output is not stalled.
//   the critical path is the index shift (small multiply, barrel shift) and
//   the 49 bit request address add
// reset and stall
//   rst_n clears the registers and leaves the walker idle. while m_tready is
//   low the output register holds its item; one more item can still be taken
//   into the input register before s_tready drops
// ----------------------------------------------------------------------------
module page_table_walker_top
    import ptw_pkg::*;
#(
    parameter int PAGE_SHIFT = 12
)
(
    input  logic         clk,
    input  logic         rst_n,

    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // virtual_address[63:0], entry_data[127:64]
    input  logic         s_tuser,   // operation[0]

    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // read_address[48:0], walk_level[51:49],
                                    // table_index[63:52], block_shift[69:64],
                                    // final_entry[133:70], zero[135:134]
    output logic [1:0]   m_tuser,   // status[1:0]

    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    logic [31:0]  ctrl_low_reg;
    logic [31:0]  ctrl_high_reg;
    logic [63:0]  root_low_reg;
    logic [63:0]  root_high_reg;
    ptw_reg_idx_t reg_sel;
    logic         cfg_write;

    assign pready    = 1'b1;
    assign reg_sel   = paddr[4:3];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_low_reg  <= '0;
            ctrl_high_reg <= '0;
            root_low_reg  <= '0;
            root_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_CTRL_LOW:  ctrl_low_reg  <= pwdata[31:0];
                REG_CTRL_HIGH: ctrl_high_reg <= pwdata[31:0];
                REG_ROOT_LOW:  root_low_reg  <= pwdata;
                REG_ROOT_HIGH: root_high_reg <= pwdata;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_CTRL_LOW:  prdata = {32'd0, ctrl_low_reg};
            REG_CTRL_HIGH: prdata = {32'd0, ctrl_high_reg};
            REG_ROOT_LOW:  prdata = root_low_reg;
            REG_ROOT_HIGH: prdata = root_high_reg;
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // input register
    // ------------------------------------------------------------------------
    logic        in_valid_reg;
    logic        in_op_reg;
    logic [63:0] in_va_reg;
    logic [63:0] in_entry_reg;
    logic        out_valid_reg;
    logic        advance;
    logic        proc;

    // the output register is free or being emptied this cycle
    assign advance  = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_op_reg    <= s_tuser;
            in_va_reg    <= s_tdata[63:0];
            in_entry_reg <= s_tdata[127:64];
        end
    end

    // ------------------------------------------------------------------------
    // walk state
    // ------------------------------------------------------------------------
    // the table base of a step is used only by the request of that same step,
    // so it is taken straight from the root or the entry and not kept
    logic               busy_reg;
    logic [63:0]        held_reg;
    ptw_level_t         level_reg;

    // decode of the walk-control words
    logic [2:0] depth;
    logic [4:0] width;
    logic       bad;

    always_comb
    begin
        priority if (ctrl_high_reg[23:18] != 6'd0)
            depth = 3'd5;
        else if (ctrl_high_reg[11:6] != 6'd0)
            depth = 3'd4;
        else if (ctrl_low_reg[30:25] != 6'd0)
            depth = 3'd3;
        else
            depth = 3'd0;
    end

    assign width = ctrl_low_reg[9:5];
    assign bad   = (depth == 3'd0) || (width == 5'd0) || (width > MAX_WIDTH);

    // entry checks
    logic       is_start;
    logic       entry_zero;
    logic       entry_huge;
    logic       at_last;
    logic       stop;
    logic       produce;

    assign is_start   = (in_op_reg == OP_START);
    assign entry_zero = (in_entry_reg == 64'd0);
    assign entry_huge = in_entry_reg[HUGE_BIT_A] && in_entry_reg[HUGE_BIT_B];
    assign at_last    = ({1'b0, level_reg} + 4'd1) >= {1'b0, depth};
    assign stop       = entry_zero || entry_huge || at_last;
    assign produce    = is_start || busy_reg;

    // level whose index is reported: 0 on a start, the current level when
    // the walk ends, the next level when it goes on
    ptw_level_t calc_lvl;
    logic [3:0] lvl_p1;
    logic [2:0] below;
    logic [7:0] prod;
    logic [7:0] shift_full;
    logic [63:0] eff_addr;
    logic [63:0] shifted;
    logic [12:0] wmask;
    logic [INDEX_W-1:0] idx;

    always_comb
    begin
        if (is_start)
            calc_lvl = '0;
        else if (stop)
            calc_lvl = level_reg;
        else
            calc_lvl = level_reg + 3'd1;
    end

    assign lvl_p1     = {1'b0, calc_lvl} + 4'd1;
    assign below      = (lvl_p1 < {1'b0, depth}) ? 3'(({1'b0, depth}) - lvl_p1) : 3'd0;
    assign prod       = 8'(below) * 8'(width);
    assign shift_full = prod + 8'(PAGE_SHIFT);
    assign eff_addr   = is_start ? in_va_reg : held_reg;
    assign shifted    = eff_addr >> shift_full[5:0];
    assign wmask      = ~(13'h1FFF << width);
    assign idx        = (shift_full >= 8'd64) ? '0 : (shifted[INDEX_W-1:0] & wmask[INDEX_W-1:0]);

    // table base of the request
    logic [63:0]        root_sel;
    logic [BASE_W-1:0]  req_base;
    logic [RADDR_W-1:0] req_addr;

    assign root_sel = in_va_reg[47] ? root_high_reg : root_low_reg;
    assign req_base = is_start ? root_sel[BASE_W-1:0] & ENTRY_ADDR_MASK[BASE_W-1:0]
                               : in_entry_reg[BASE_W-1:0] & ENTRY_ADDR_MASK[BASE_W-1:0];
    assign req_addr = {1'b0, req_base} + {{(RADDR_W-INDEX_W-3){1'b0}}, idx, 3'b000};

    // result of this item
    ptw_status_t        res_status;
    logic [RADDR_W-1:0] res_addr;
    ptw_level_t         res_level;
    logic [INDEX_W-1:0] res_index;
    logic [5:0]         res_shift;
    logic [63:0]        res_entry;

    always_comb
    begin
        res_status = ST_READ_REQ;
        res_addr   = req_addr;
        res_level  = calc_lvl;
        res_index  = idx;
        res_shift  = shift_full[5:0];
        res_entry  = '0;
        if (bad)
        begin
            res_status = ST_UNSUP;
            res_addr   = '0;
            res_level  = '0;
            res_index  = '0;
            res_shift  = '0;
        end
        else if (!is_start && stop)
        begin
            res_status = at_last ? ST_LAST : ST_EARLY;
            res_addr   = '0;
            res_entry  = in_entry_reg;
        end
    end

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            held_reg  <= '0;
            level_reg <= '0;
        end
        else if (proc && produce)
        begin
            if (bad)
            begin
                busy_reg <= 1'b0;
            end
            else if (is_start)
            begin
                busy_reg  <= 1'b1;
                held_reg  <= in_va_reg;
                level_reg <= '0;
            end
            else if (stop)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                level_reg <= calc_lvl;
            end
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    ptw_status_t        out_status_reg;
    logic [RADDR_W-1:0] out_addr_reg;
    ptw_level_t         out_level_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [5:0]         out_shift_reg;
    logic [63:0]        out_entry_reg;
    logic               out_valid_next;

    assign out_valid_next = proc ? produce : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc && produce)
        begin
            out_status_reg <= res_status;
            out_addr_reg   <= res_addr;
            out_level_reg  <= res_level;
            out_index_reg  <= res_index;
            out_shift_reg  <= res_shift;
            out_entry_reg  <= res_entry;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {2'b00, out_entry_reg, out_shift_reg, out_index_reg,
                       out_level_reg, out_addr_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    // the walk level never passes the deepest table
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= 3'd4)
        else $error("walk level out of range");

    // a pending read request belongs to a running walk
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_READ_REQ)) |-> busy_reg)
        else $error("read request without a running walk");

    // a walk end leaves the walker idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_READ_REQ)) |-> !busy_reg)
        else $error("walk ended but walker still busy");

    // an unsupported config never starts a walk
    a_bad_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && bad) |=> !busy_reg)
        else $error("walk running on unsupported config");

endmodule
